FILE: sv/amrdf_pkg.sv
// ----------------------------------------------------------------------------
// amrdf_pkg
// Shared widths, result codes, beat type and frame size tables for the
// octet-aligned AMR payload deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package amrdf_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 12;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 3;
   localparam int ENTRY_W = 5;
   localparam int SIZE_W  = 6;

   // follow bit of a table-of-contents byte
   localparam int FOLLOW_BIT = 7;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SPEECH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

   // packet status codes
   localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_SPEECH = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_TRUNC     = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_EXCESS    = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_TOO_MANY  = 3'd4;

   // one result beat
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [KIND_W-1:0] out_kind;
      logic [STAT_W-1:0] packet_status;
      logic              last_of_packet;
   } rsp_beat_type;

   // speech byte count of a frame type, narrowband or wideband
   function automatic logic [SIZE_W-1:0] frame_size(input logic wideband,
                                                   input logic [3:0] ftype);
      logic [SIZE_W-1:0] nb;
      logic [SIZE_W-1:0] wb;
      case (ftype)
         4'd0:    begin nb = 6'd12; wb = 6'd17; end
         4'd1:    begin nb = 6'd13; wb = 6'd23; end
         4'd2:    begin nb = 6'd15; wb = 6'd32; end
         4'd3:    begin nb = 6'd17; wb = 6'd36; end
         4'd4:    begin nb = 6'd19; wb = 6'd40; end
         4'd5:    begin nb = 6'd20; wb = 6'd46; end
         4'd6:    begin nb = 6'd26; wb = 6'd50; end
         4'd7:    begin nb = 6'd31; wb = 6'd58; end
         4'd8:    begin nb = 6'd5;  wb = 6'd60; end
         4'd9:    begin nb = 6'd0;  wb = 6'd5;  end
         4'd10:   begin nb = 6'd0;  wb = 6'd5;  end
         default: begin nb = 6'd0;  wb = 6'd0;  end
      endcase
      return wideband ? wb : nb;
   endfunction

endpackage

`default_nettype wire

FILE: sv/amrdf_if.sv
// ----------------------------------------------------------------------------
// amrdf_if
// Valid/ready channels of the deframer: payload bytes in, result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

// payload byte channel
interface amrdf_req_if;
   logic                         valid;
   logic                         ready;
   logic [amrdf_pkg::BYTE_W-1:0] payload_byte;
   logic [amrdf_pkg::LEN_W-1:0]  packet_length;

   modport source (output valid, output payload_byte, output packet_length, input ready);
   modport sink   (input valid, input payload_byte, input packet_length, output ready);
endinterface

// result channel
interface amrdf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [amrdf_pkg::BYTE_W-1:0] out_byte;
   logic [amrdf_pkg::KIND_W-1:0] out_kind;
   logic [amrdf_pkg::STAT_W-1:0] packet_status;
   logic                         last_of_packet;

   modport source (output valid, output out_byte, output out_kind, output packet_status,
                   output last_of_packet, input ready);
   modport sink   (input valid, input out_byte, input out_kind, input packet_status,
                   input last_of_packet, output ready);
endinterface

`default_nettype wire

FILE: sv/amrdf_toc_ram.sv
// ----------------------------------------------------------------------------
// amrdf_toc_ram
// Table-of-contents store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module amrdf_toc_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [amrdf_pkg::ENTRY_W-1:0] wr_data,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [amrdf_pkg::ENTRY_W-1:0] rd_data
);

   logic [amrdf_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [amrdf_pkg::ENTRY_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/amrdf_rsp_reg.sv
// ----------------------------------------------------------------------------
// amrdf_rsp_reg
// Output register of the result channel; takes a new beat while the held
// one is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module amrdf_rsp_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire amrdf_pkg::rsp_beat_type push_beat,
   output logic                         can_push,
   amrdf_rsp_if.source                  rsp
);

   logic                    valid_ff;
   amrdf_pkg::rsp_beat_type beat_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (push) begin
         beat_ff <= push_beat;
      end
   end

   assign can_push           = !valid_ff || rsp.ready;
   assign rsp.valid          = valid_ff;
   assign rsp.out_byte       = beat_ff.out_byte;
   assign rsp.out_kind       = beat_ff.out_kind;
   assign rsp.packet_status  = beat_ff.packet_status;
   assign rsp.last_of_packet = beat_ff.last_of_packet;

endmodule

`default_nettype wire

FILE: sv/amrdf_ctrl.sv
// ----------------------------------------------------------------------------
// amrdf_ctrl
// Packet sequencer: parses the mode request and table of contents, walks the
// stored entries through the toc memory and emits header, speech and end beats.
// ----------------------------------------------------------------------------
`default_nettype none

module amrdf_ctrl #(
   parameter int MAX_FRAMES       = 16,
   parameter int MAX_PACKET_BYTES = 2048,
   parameter int IDX_W            = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wideband,
   amrdf_req_if.sink                          req,
   // toc memory
   output logic                               toc_wr_en,
   output logic      [IDX_W-1:0]              toc_wr_addr,
   output logic      [amrdf_pkg::ENTRY_W-1:0] toc_wr_data,
   output logic                               toc_rd_en,
   output logic      [IDX_W-1:0]              toc_rd_addr,
   input  wire logic [amrdf_pkg::ENTRY_W-1:0] toc_rd_data,
   // result register
   output logic                               push,
   output amrdf_pkg::rsp_beat_type            push_beat,
   input  wire logic                          can_push
);

   localparam int FC_W  = $clog2(MAX_FRAMES + 1);
   localparam int LEN_W = amrdf_pkg::LEN_W;
   localparam int CMP_W = LEN_W + 1;

   typedef enum logic [6:0] {
      S_IN   = 7'b0000001,
      S_HRD  = 7'b0000010,
      S_HCHK = 7'b0000100,
      S_DATA = 7'b0001000,
      S_ZRD  = 7'b0010000,
      S_ZCHK = 7'b0100000,
      S_END  = 7'b1000000
   } ctrl_state_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_TOC    = 4'b0010,
      PH_SPEECH = 4'b0100,
      PH_DRAIN  = 4'b1000
   } phase_type;

   ctrl_state_type                 state_ff, state_in;
   phase_type                      phase_ff, phase_in;
   logic [LEN_W-1:0]               pos_ff, pos_in;
   logic [LEN_W-1:0]               len_ff, len_in;
   logic [FC_W-1:0]                fc_ff, fc_in;
   logic [FC_W-1:0]                cf_ff, cf_in;
   logic [amrdf_pkg::SIZE_W-1:0]   left_ff, left_in;
   logic [LEN_W-1:0]               offset_ff, offset_in;
   logic [amrdf_pkg::STAT_W-1:0]   status_ff, status_in;
   logic                           last_ff, last_in;
   logic [amrdf_pkg::BYTE_W-1:0]   held_ff, held_in;

   logic                           accept;
   logic [LEN_W-1:0]               len_clamp;
   logic [LEN_W-1:0]               pos_inc;
   logic                           is_last;
   logic                           fc_full;
   logic                           cf_lt_fc;
   logic                           cf_inc_lt_fc;
   logic [FC_W-1:0]                cf_inc;
   logic [amrdf_pkg::SIZE_W-1:0]   entry_size;
   logic [amrdf_pkg::BYTE_W-1:0]   entry_hdr;
   logic [CMP_W-1:0]               offset_sum;
   logic                           entry_fits;
   logic [amrdf_pkg::STAT_W-1:0]   end_status;
   ctrl_state_type                 done_state;

   // input handshake
   assign req.ready = (state_ff == S_IN) && can_push;
   assign accept    = req.valid && req.ready;

   // packet length, clamped to 1 .. max
   always_comb begin
      len_clamp = req.packet_length;
      if (req.packet_length == '0) begin
         len_clamp = LEN_W'(1);
      end else if (32'(req.packet_length) > MAX_PACKET_BYTES) begin
         len_clamp = LEN_W'(MAX_PACKET_BYTES);
      end
   end

   // position and frame bookkeeping
   assign pos_inc      = pos_ff + LEN_W'(1);
   assign is_last      = (phase_ff == PH_IDLE) ? (len_clamp == LEN_W'(1)) : (pos_inc >= len_ff);
   assign fc_full      = (fc_ff == FC_W'(MAX_FRAMES));
   assign cf_inc       = cf_ff + FC_W'(1);
   assign cf_lt_fc     = (cf_ff < fc_ff);
   assign cf_inc_lt_fc = (cf_inc < fc_ff);
   assign done_state   = last_ff ? S_END : S_IN;

   // entry read back from the toc memory
   assign entry_size = amrdf_pkg::frame_size(wideband, toc_rd_data[4:1]);
   assign entry_hdr  = {1'b0, toc_rd_data, 2'b00};
   assign offset_sum = CMP_W'(offset_ff) + CMP_W'(entry_size);
   assign entry_fits = (offset_sum <= CMP_W'(len_ff));

   // end marker status: frames still pending count as truncated
   assign end_status = ((phase_ff == PH_SPEECH) && cf_lt_fc) ? amrdf_pkg::STATUS_TRUNC
                                                              : status_ff;

   // memory ports
   assign toc_wr_addr = fc_ff[IDX_W-1:0];
   assign toc_wr_data = req.payload_byte[6:2];
   assign toc_rd_en   = (state_ff == S_HRD) || (state_ff == S_ZRD);
   assign toc_rd_addr = cf_ff[IDX_W-1:0];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      fc_in     = fc_ff;
      cf_in     = cf_ff;
      left_in   = left_ff;
      offset_in = offset_ff;
      status_in = status_ff;
      last_in   = last_ff;
      held_in   = held_ff;
      toc_wr_en = 1'b0;
      push      = 1'b0;
      push_beat = '0;

      unique case (state_ff)
         S_IN: begin
            if (accept) begin
               last_in  = is_last;
               state_in = is_last ? S_END : S_IN;
               if (phase_ff == PH_IDLE) begin
                  // mode request byte opens the packet
                  len_in    = len_clamp;
                  pos_in    = LEN_W'(1);
                  fc_in     = '0;
                  cf_in     = '0;
                  left_in   = '0;
                  offset_in = '0;
                  status_in = (len_clamp == LEN_W'(1)) ? amrdf_pkg::STATUS_NO_SPEECH
                                                        : amrdf_pkg::STATUS_OK;
                  phase_in  = PH_TOC;
               end else begin
                  pos_in = pos_inc;
                  unique case (phase_ff)
                     PH_TOC: begin
                        if (fc_full) begin
                           status_in = amrdf_pkg::STATUS_TOO_MANY;
                           phase_in  = PH_DRAIN;
                        end else begin
                           toc_wr_en = 1'b1;
                           fc_in     = fc_ff + FC_W'(1);
                           if (is_last) begin
                              status_in = amrdf_pkg::STATUS_NO_SPEECH;
                              phase_in  = PH_DRAIN;
                           end else if (!req.payload_byte[amrdf_pkg::FOLLOW_BIT]) begin
                              phase_in  = PH_SPEECH;
                              offset_in = pos_inc;
                           end
                        end
                     end
                     PH_SPEECH: begin
                        if (left_ff != '0) begin
                           // speech byte inside a frame
                           push                     = 1'b1;
                           push_beat.out_byte       = req.payload_byte;
                           push_beat.out_kind       = amrdf_pkg::KIND_SPEECH;
                           left_in                  = left_ff - amrdf_pkg::SIZE_W'(1);
                           if ((left_ff == amrdf_pkg::SIZE_W'(1)) && cf_lt_fc) begin
                              state_in = S_ZRD;
                           end
                        end else if (cf_lt_fc) begin
                           // first byte of a frame: header comes first
                           held_in  = req.payload_byte;
                           state_in = S_HRD;
                        end else begin
                           status_in = amrdf_pkg::STATUS_EXCESS;
                        end
                     end
                     PH_DRAIN: begin
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_HRD: begin
            state_in = S_HCHK;
         end
         S_HCHK: begin
            if (!entry_fits) begin
               status_in = amrdf_pkg::STATUS_TRUNC;
               phase_in  = PH_DRAIN;
               state_in  = done_state;
            end else if (can_push) begin
               push               = 1'b1;
               push_beat.out_byte = entry_hdr;
               push_beat.out_kind = amrdf_pkg::KIND_HEADER;
               cf_in              = cf_inc;
               offset_in          = offset_sum[LEN_W-1:0];
               if (entry_size != '0) begin
                  left_in  = entry_size;
                  state_in = S_DATA;
               end else if (cf_inc_lt_fc) begin
                  state_in = S_HRD;
               end else begin
                  status_in = amrdf_pkg::STATUS_EXCESS;
                  state_in  = done_state;
               end
            end
         end
         S_DATA: begin
            if (can_push) begin
               push               = 1'b1;
               push_beat.out_byte = held_ff;
               push_beat.out_kind = amrdf_pkg::KIND_SPEECH;
               left_in            = left_ff - amrdf_pkg::SIZE_W'(1);
               if ((left_ff == amrdf_pkg::SIZE_W'(1)) && cf_lt_fc) begin
                  state_in = S_ZRD;
               end else begin
                  state_in = done_state;
               end
            end
         end
         S_ZRD: begin
            state_in = S_ZCHK;
         end
         S_ZCHK: begin
            // headers of zero-size frames after a frame's last byte
            if (entry_size != '0) begin
               state_in = done_state;
            end else if (can_push) begin
               push               = 1'b1;
               push_beat.out_byte = entry_hdr;
               push_beat.out_kind = amrdf_pkg::KIND_HEADER;
               cf_in              = cf_inc;
               state_in           = cf_inc_lt_fc ? S_ZRD : done_state;
            end
         end
         S_END: begin
            if (can_push) begin
               push                     = 1'b1;
               push_beat.out_kind       = amrdf_pkg::KIND_END;
               push_beat.packet_status  = end_status;
               push_beat.last_of_packet = 1'b1;
               phase_in                 = PH_IDLE;
               pos_in                   = '0;
               state_in                 = S_IN;
            end
         end
         default: begin
            state_in = S_IN;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IN;
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         len_ff    <= '0;
         fc_ff     <= '0;
         cf_ff     <= '0;
         left_ff   <= '0;
         offset_ff <= '0;
         status_ff <= '0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         fc_ff     <= fc_in;
         cf_ff     <= cf_in;
         left_ff   <= left_in;
         offset_ff <= offset_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   // held speech byte
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

FILE: sv/amr_rtp_payload_deframer.sv
// ----------------------------------------------------------------------------
// amr_rtp_payload_deframer
// Octet-aligned AMR RTP payload deframer: one payload byte per input beat,
// header, speech and end-of-packet beats out.
// ----------------------------------------------------------------------------
// Usage:
//  req_bus carries one payload byte per beat; packet_length is sampled on the
//  first byte of each packet (the mode request, which is dropped).
//  rsp_bus carries header beats (masked toc byte), speech beats and one
//  end-of-packet beat per packet with the packet status and last_of_packet.
//  csr_wr_en/csr_wr_data select the wideband size table; write it only while
//  no packet is in progress.
//  Sequencing: toc bytes, trailing bytes and speech bytes inside a frame are
//  taken straight in the input state while the output register has room.
//  The first speech byte of a frame goes through accept, toc memory read,
//  header beat and speech beat; each zero-size frame adds a memory read and
//  a header beat. The end marker follows the last byte in its own state. The
//  single toc read port sets these steps. A result is registered and shows
//  on rsp_bus the cycle after it is formed. Reset clears the sequencer and
//  the output register; the toc memory is not cleared. A stalled receiver
//  holds the output beat and req_bus.ready stays low until the beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module amr_rtp_payload_deframer #(
   parameter int MAX_FRAMES       = 16,
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  wire logic clock,
   input  wire logic reset,
   amrdf_req_if.sink   req_bus,
   amrdf_rsp_if.source rsp_bus,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   logic                          wideband_ff;
   logic                          toc_wr_en;
   logic [IDX_W-1:0]              toc_wr_addr;
   logic [amrdf_pkg::ENTRY_W-1:0] toc_wr_data;
   logic                          toc_rd_en;
   logic [IDX_W-1:0]              toc_rd_addr;
   logic [amrdf_pkg::ENTRY_W-1:0] toc_rd_data;
   logic                          push;
   amrdf_pkg::rsp_beat_type       push_beat;
   logic                          can_push;

   // size table select register
   always_ff @(posedge clock) begin
      if (reset) begin
         wideband_ff <= 1'b0;
      end else if (csr_wr_en) begin
         wideband_ff <= csr_wr_data;
      end
   end

   amrdf_ctrl #(
      .MAX_FRAMES       (MAX_FRAMES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .IDX_W            (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .wideband    (wideband_ff),
      .req         (req_bus),
      .toc_wr_en   (toc_wr_en),
      .toc_wr_addr (toc_wr_addr),
      .toc_wr_data (toc_wr_data),
      .toc_rd_en   (toc_rd_en),
      .toc_rd_addr (toc_rd_addr),
      .toc_rd_data (toc_rd_data),
      .push        (push),
      .push_beat   (push_beat),
      .can_push    (can_push)
   );

   amrdf_toc_ram #(
      .DEPTH  (MAX_FRAMES),
      .ADDR_W (IDX_W)
   ) u_toc_ram (
      .clock   (clock),
      .wr_en   (toc_wr_en),
      .wr_addr (toc_wr_addr),
      .wr_data (toc_wr_data),
      .rd_en   (toc_rd_en),
      .rd_addr (toc_rd_addr),
      .rd_data (toc_rd_data)
   );

   amrdf_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .can_push  (can_push),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: sv/amrdf_checker.sv
// ----------------------------------------------------------------------------
// amrdf_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module amrdf_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [amrdf_pkg::BYTE_W-1:0] out_byte,
   input wire logic [amrdf_pkg::KIND_W-1:0] out_kind,
   input wire logic [amrdf_pkg::STAT_W-1:0] packet_status,
   input wire logic                         last_of_packet
);

   // a stalled result beat stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a stalled result beat keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_byte) && $stable(out_kind)
                                  && $stable(packet_status) && $stable(last_of_packet))
      else $error("result payload changed while stalled");

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // no new byte is taken while a result beat is stuck
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("payload byte taken while result stalled");

   // end marker and only it closes a packet, with a zero byte; others carry no status
   a_end_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_of_packet == (out_kind == amrdf_pkg::KIND_END))
                    && (!last_of_packet || (out_byte == '0))
                    && (last_of_packet || (packet_status == amrdf_pkg::STATUS_OK)))
      else $error("malformed end-of-packet beat");

endmodule

bind amr_rtp_payload_deframer amrdf_checker u_amrdf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .out_byte       (rsp_bus.out_byte),
   .out_kind       (rsp_bus.out_kind),
   .packet_status  (rsp_bus.packet_status),
   .last_of_packet (rsp_bus.last_of_packet)
);

`default_nettype wire
